/* design/scr_pkg.sv */
`default_nettype none
package scr_pkg;

  // segment sample limit and derived widths
  localparam int MAX_SEG = 62;
  localparam int NW = $clog2(MAX_SEG + 1);
  localparam int DIV_BITS = 21;
  localparam int DCW = $clog2(DIV_BITS + 1);
  localparam int ACC_W = 44;
  localparam logic signed [16:0] FIRST_STEP = 17'sd480;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOAD,
    OP_SQ,
    OP_DROP,
    OP_CNT_START,
    OP_CNT_STEP,
    OP_SETUP1,
    OP_SETUP2,
    OP_H1,
    OP_H2,
    OP_H3,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EMIT_HIST,
    OP_EMIT_SPL
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic short_step;
    logic d2_zero;
    logic cnt_hit;
    logic n_one;
    logic div_done;
    logic last_sample;
    logic out_free;
  } stat_t;

  // clamp to 16 bit signed
  function automatic logic [15:0] sat16(input logic signed [21:0] v);
    logic [15:0] r;
    if (v > 22'sd32767) r = 16'h7fff;
    else if (v < -22'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/scr_dp.sv */
`default_nettype none
module scr_dp (
  input  wire                clk,
  input  wire                rst,
  input  scr_pkg::cmd_t      cmd,
  input  wire         [14:0] spacing,
  input  wire  signed [15:0] touch_x,
  input  wire  signed [15:0] touch_y,
  input  wire                out_ready,
  output logic               out_valid,
  output logic signed [15:0] point_x,
  output logic signed [15:0] point_y,
  output logic signed [15:0] vel_x,
  output logic signed [15:0] vel_y,
  output logic               last,
  output scr_pkg::stat_t     stat
);

  // history
  logic signed [15:0] pos_x [4];
  logic signed [15:0] pos_y [4];
  logic signed [16:0] stp_x [4];
  logic signed [16:0] stp_y [4];

  // segment control
  logic [33:0] d2;
  logic [scr_pkg::NW-1:0] n;
  logic [scr_pkg::NW-1:0] i;
  logic [20:0] r;
  logic [11:0] mm;
  logic [17:0] mmm;
  logic [38:0] dsh;
  logic [scr_pkg::DCW-1:0] dcnt;

  // per lane: pos x, pos y, step x, step y
  logic signed [20:0] c1 [4];
  logic signed [20:0] c2 [4];
  logic signed [20:0] c3 [4];
  logic signed [20:0] aa [4];
  logic signed [scr_pkg::ACC_W-1:0] t [4];
  logic [scr_pkg::ACC_W-1:0] p [4];
  logic [scr_pkg::DIV_BITS-1:0] q [4];
  logic neg [4];

  logic [1:0] rd_idx;
  logic signed [15:0] rd_px, rd_py;
  logic signed [16:0] rd_sx, rd_sy;
  logic [14:0] sp_eff;
  logic [29:0] s2;
  logic [41:0] rr;
  logic signed [33:0] sqx, sqy;
  logic [scr_pkg::NW-1:0] m;
  logic signed [16:0] av [4][4];
  logic signed [20:0] e [4][4];
  logic signed [scr_pkg::ACC_W-1:0] si, sm, smm, smmm;
  logic signed [scr_pkg::ACC_W-1:0] t_next [4];
  logic signed [scr_pkg::ACC_W-1:0] nval [4];
  logic [15:0] res [4];

  // one read port per history array
  assign rd_idx = (cmd.op == scr_pkg::OP_LOAD) ? cmd.idx - 2'd1 : cmd.idx;
  assign rd_px = pos_x[rd_idx];
  assign rd_py = pos_y[rd_idx];
  assign rd_sx = stp_x[rd_idx];
  assign rd_sy = stp_y[rd_idx];

  // spacing terms and length compare
  assign sp_eff = (spacing == 15'd0) ? 15'd1 : spacing;
  assign s2 = 30'(sp_eff) * 30'(sp_eff);
  assign sqx = 34'(rd_sx) * 34'(rd_sx);
  assign sqy = 34'(rd_sy) * 34'(rd_sy);
  assign rr = 42'(r) * 42'(r);
  assign m = n - scr_pkg::NW'(1);

  // lane operands and polynomial step
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      av[0][k] = 17'(pos_x[k]);
      av[1][k] = 17'(pos_y[k]);
      av[2][k] = stp_x[k];
      av[3][k] = stp_y[k];
    end
    for (int l = 0; l < 4; l++) begin
      for (int k = 0; k < 4; k++) begin
        e[l][k] = 21'(av[l][k]);
      end
    end
    si = $signed(scr_pkg::ACC_W'(i));
    sm = $signed(scr_pkg::ACC_W'(m));
    smm = $signed(scr_pkg::ACC_W'(mm));
    smmm = $signed(scr_pkg::ACC_W'(mmm));
    for (int l = 0; l < 4; l++) begin
      unique case (cmd.op)
        scr_pkg::OP_H1:
          t_next[l] = scr_pkg::ACC_W'(c3[l]) * si + scr_pkg::ACC_W'(c2[l]) * sm;
        scr_pkg::OP_H2:
          t_next[l] = t[l] * si + scr_pkg::ACC_W'(c1[l]) * smm;
        default:
          t_next[l] = t[l] * si + scr_pkg::ACC_W'(aa[l]) * smmm;
      endcase
      nval[l] = t[l] + smmm;
      res[l] = scr_pkg::sat16(neg[l] ? ~$signed({1'b0, q[l]}) : $signed({1'b0, q[l]}));
    end
  end

  // status
  always_comb begin
    stat.short_step = d2 < 34'(s2);
    stat.d2_zero = (d2 == 34'd0);
    stat.cnt_hit = (42'(d2) <= rr) || (n == scr_pkg::NW'(scr_pkg::MAX_SEG));
    stat.n_one = (n == scr_pkg::NW'(1));
    stat.div_done = (dcnt == scr_pkg::DCW'(scr_pkg::DIV_BITS));
    stat.last_sample = (i == m);
    stat.out_free = !out_valid || out_ready;
  end

  // history updates
  always_ff @(posedge clk) begin
    if (rst || cmd.op == scr_pkg::OP_CLEAR) begin
      for (int k = 0; k < 4; k++) begin
        pos_x[k] <= '0;
        pos_y[k] <= '0;
        stp_x[k] <= '0;
        stp_y[k] <= '0;
      end
    end else if (cmd.op == scr_pkg::OP_LOAD) begin
      pos_x[cmd.idx] <= touch_x;
      pos_y[cmd.idx] <= touch_y;
      if (cmd.idx == 2'd0) begin
        stp_x[0] <= scr_pkg::FIRST_STEP;
        stp_y[0] <= scr_pkg::FIRST_STEP;
      end else begin
        stp_x[cmd.idx] <= 17'(touch_x) - 17'(rd_px);
        stp_y[cmd.idx] <= 17'(touch_y) - 17'(rd_py);
      end
    end else if (cmd.op == scr_pkg::OP_DROP) begin
      for (int k = 0; k < 3; k++) begin
        pos_x[k] <= pos_x[k + 1];
        pos_y[k] <= pos_y[k + 1];
        stp_x[k] <= stp_x[k + 1];
        stp_y[k] <= stp_y[k + 1];
      end
    end
  end

  // length, count, spline and divider sequencing
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      scr_pkg::OP_SQ: d2 <= $unsigned(sqx) + $unsigned(sqy);
      scr_pkg::OP_CNT_START: begin
        n <= scr_pkg::NW'(1);
        r <= 21'(sp_eff);
      end
      scr_pkg::OP_CNT_STEP: begin
        n <= n + scr_pkg::NW'(1);
        r <= r + 21'(sp_eff);
      end
      scr_pkg::OP_SETUP1: begin
        mm <= 12'(m) * 12'(m);
        i <= '0;
        for (int l = 0; l < 4; l++) begin
          c1[l] <= e[l][2] - e[l][0];
          c2[l] <= (e[l][0] <<< 1) - (e[l][1] <<< 2) - e[l][1] + (e[l][2] <<< 2) - e[l][3];
          c3[l] <= e[l][3] - e[l][0] + (e[l][1] <<< 1) + e[l][1] - (e[l][2] <<< 1) - e[l][2];
          aa[l] <= e[l][1] <<< 1;
        end
      end
      scr_pkg::OP_SETUP2: mmm <= 18'(mm) * 18'(m);
      scr_pkg::OP_H1, scr_pkg::OP_H2, scr_pkg::OP_H3: begin
        for (int l = 0; l < 4; l++) t[l] <= t_next[l];
      end
      scr_pkg::OP_DIV_INIT: begin
        dsh <= {mmm, 21'b0};
        dcnt <= '0;
        for (int l = 0; l < 4; l++) begin
          neg[l] <= nval[l][scr_pkg::ACC_W-1];
          p[l] <= nval[l][scr_pkg::ACC_W-1] ? ~nval[l] : nval[l];
          q[l] <= '0;
        end
      end
      scr_pkg::OP_DIV_STEP: begin
        dsh <= dsh >> 1;
        dcnt <= dcnt + scr_pkg::DCW'(1);
        for (int l = 0; l < 4; l++) begin
          if (p[l] >= scr_pkg::ACC_W'(dsh)) begin
            p[l] <= p[l] - scr_pkg::ACC_W'(dsh);
            q[l] <= {q[l][scr_pkg::DIV_BITS-2:0], 1'b1};
          end else begin
            q[l] <= {q[l][scr_pkg::DIV_BITS-2:0], 1'b0};
          end
        end
      end
      scr_pkg::OP_EMIT_SPL: i <= i + scr_pkg::NW'(1);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == scr_pkg::OP_EMIT_HIST || cmd.op == scr_pkg::OP_EMIT_SPL) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == scr_pkg::OP_EMIT_HIST) begin
      point_x <= rd_px;
      point_y <= rd_py;
      vel_x <= scr_pkg::sat16(22'(rd_sx));
      vel_y <= scr_pkg::sat16(22'(rd_sy));
      last <= cmd.last;
    end else if (cmd.op == scr_pkg::OP_EMIT_SPL) begin
      point_x <= res[0];
      point_y <= res[1];
      vel_x <= res[2];
      vel_y <= res[3];
      last <= cmd.last;
    end
  end

endmodule
`default_nettype wire

/* design/scr_ctrl.sv */
`default_nettype none
module scr_ctrl (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_valid,
  input  wire            action,
  output logic           in_ready,
  input  scr_pkg::stat_t stat,
  output scr_pkg::cmd_t  cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_FIRST  = 5'd1;
  localparam logic [4:0] S_SQ2    = 5'd2;
  localparam logic [4:0] S_CHK2   = 5'd3;
  localparam logic [4:0] S_E2     = 5'd4;
  localparam logic [4:0] S_SQ3    = 5'd5;
  localparam logic [4:0] S_CHK3   = 5'd6;
  localparam logic [4:0] S_E3A    = 5'd7;
  localparam logic [4:0] S_E3B    = 5'd8;
  localparam logic [4:0] S_DROP2  = 5'd9;
  localparam logic [4:0] S_DROP1  = 5'd10;
  localparam logic [4:0] S_SQ4    = 5'd11;
  localparam logic [4:0] S_SQ4B   = 5'd12;
  localparam logic [4:0] S_ZCHK   = 5'd13;
  localparam logic [4:0] S_CNT    = 5'd14;
  localparam logic [4:0] S_EMIT1  = 5'd15;
  localparam logic [4:0] S_SETUP1 = 5'd16;
  localparam logic [4:0] S_SETUP2 = 5'd17;
  localparam logic [4:0] S_H1     = 5'd18;
  localparam logic [4:0] S_H2     = 5'd19;
  localparam logic [4:0] S_H3     = 5'd20;
  localparam logic [4:0] S_DIVI   = 5'd21;
  localparam logic [4:0] S_DIV    = 5'd22;
  localparam logic [4:0] S_EMITS  = 5'd23;
  localparam logic [4:0] S_AFTER  = 5'd24;

  logic [4:0] state, state_next;
  logic [1:0] hc, hc_next;
  logic short_b, short_b_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hc <= 2'd0;
      short_b <= 1'b0;
    end else begin
      state <= state_next;
      hc <= hc_next;
      short_b <= short_b_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // sequencing
  always_comb begin
    state_next = state;
    hc_next = hc;
    short_b_next = short_b;
    cmd.op = scr_pkg::OP_NOP;
    cmd.idx = 2'd0;
    cmd.last = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && action) begin
          cmd.op = scr_pkg::OP_CLEAR;
          hc_next = 2'd0;
        end else if (in_valid) begin
          cmd.op = scr_pkg::OP_LOAD;
          cmd.idx = hc;
          unique case (hc)
            2'd0: state_next = S_FIRST;
            2'd1: state_next = S_SQ2;
            2'd2: state_next = S_SQ3;
            default: state_next = S_SQ4;
          endcase
        end
      end
      S_FIRST: begin
        if (stat.out_free) begin
          cmd.op = scr_pkg::OP_EMIT_HIST;
          cmd.idx = 2'd0;
          cmd.last = 1'b1;
          hc_next = 2'd1;
          state_next = S_IDLE;
        end
      end
      S_SQ2: begin
        cmd.op = scr_pkg::OP_SQ;
        cmd.idx = 2'd1;
        state_next = S_CHK2;
      end
      S_CHK2: begin
        if (stat.short_step) begin
          state_next = S_E2;
        end else begin
          hc_next = 2'd2;
          state_next = S_IDLE;
        end
      end
      S_E2: begin
        if (stat.out_free) begin
          cmd.op = scr_pkg::OP_EMIT_HIST;
          cmd.idx = 2'd1;
          cmd.last = 1'b1;
          state_next = S_DROP1;
        end
      end
      S_SQ3: begin
        cmd.op = scr_pkg::OP_SQ;
        cmd.idx = 2'd2;
        state_next = S_CHK3;
      end
      S_CHK3: begin
        if (stat.short_step) begin
          state_next = S_E3A;
        end else begin
          hc_next = 2'd3;
          state_next = S_IDLE;
        end
      end
      S_E3A: begin
        if (stat.out_free) begin
          cmd.op = scr_pkg::OP_EMIT_HIST;
          cmd.idx = 2'd1;
          state_next = S_E3B;
        end
      end
      S_E3B: begin
        if (stat.out_free) begin
          cmd.op = scr_pkg::OP_EMIT_HIST;
          cmd.idx = 2'd2;
          cmd.last = 1'b1;
          state_next = S_DROP2;
        end
      end
      S_DROP2: begin
        cmd.op = scr_pkg::OP_DROP;
        state_next = S_DROP1;
      end
      S_DROP1: begin
        cmd.op = scr_pkg::OP_DROP;
        hc_next = 2'd1;
        state_next = S_IDLE;
      end
      // full window: check the newest step first so the last flag is known
      S_SQ4: begin
        cmd.op = scr_pkg::OP_SQ;
        cmd.idx = 2'd3;
        state_next = S_SQ4B;
      end
      S_SQ4B: begin
        short_b_next = stat.short_step;
        cmd.op = scr_pkg::OP_SQ;
        cmd.idx = 2'd2;
        state_next = S_ZCHK;
      end
      S_ZCHK: begin
        if (stat.d2_zero) begin
          state_next = S_AFTER;
        end else begin
          cmd.op = scr_pkg::OP_CNT_START;
          state_next = S_CNT;
        end
      end
      S_CNT: begin
        if (stat.cnt_hit) begin
          state_next = stat.n_one ? S_EMIT1 : S_SETUP1;
        end else begin
          cmd.op = scr_pkg::OP_CNT_STEP;
        end
      end
      S_EMIT1: begin
        if (stat.out_free) begin
          cmd.op = scr_pkg::OP_EMIT_HIST;
          cmd.idx = 2'd1;
          cmd.last = !short_b;
          state_next = S_AFTER;
        end
      end
      S_SETUP1: begin
        cmd.op = scr_pkg::OP_SETUP1;
        state_next = S_SETUP2;
      end
      S_SETUP2: begin
        cmd.op = scr_pkg::OP_SETUP2;
        state_next = S_H1;
      end
      S_H1: begin
        cmd.op = scr_pkg::OP_H1;
        state_next = S_H2;
      end
      S_H2: begin
        cmd.op = scr_pkg::OP_H2;
        state_next = S_H3;
      end
      S_H3: begin
        cmd.op = scr_pkg::OP_H3;
        state_next = S_DIVI;
      end
      S_DIVI: begin
        cmd.op = scr_pkg::OP_DIV_INIT;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_EMITS;
        end else begin
          cmd.op = scr_pkg::OP_DIV_STEP;
        end
      end
      S_EMITS: begin
        if (stat.out_free) begin
          cmd.op = scr_pkg::OP_EMIT_SPL;
          cmd.last = stat.last_sample && !short_b;
          state_next = stat.last_sample ? S_AFTER : S_H1;
        end
      end
      S_AFTER: begin
        cmd.op = scr_pkg::OP_DROP;
        hc_next = 2'd3;
        state_next = S_SQ3;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* design/stroke_catmull_rom_resampler.sv */
// a spline segment is sized by a counting loop and takes two setup steps, then per sample
// three polynomial steps, divider load, 21 divider steps and a done check, one output load
// throughput: one request at a time; a new request is taken only while the controller is idle
// reset: synchronous active-high rst empties the history and sets spacing to 160
`default_nettype none
module stroke_catmull_rom_resampler (
  input  wire                clk,
  input  wire                rst,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire         [2:0]  paddr,
  input  wire         [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                action,
  input  wire  signed [15:0] touch_x,
  input  wire  signed [15:0] touch_y,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [15:0] point_x,
  output logic signed [15:0] point_y,
  output logic signed [15:0] vel_x,
  output logic signed [15:0] vel_y,
  output logic               last
);

  logic [14:0] spacing;
  scr_pkg::cmd_t cmd;
  scr_pkg::stat_t stat;

  // spacing register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= 15'd160;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      spacing <= pwdata[14:0];
    end
  end
  assign prdata = paddr[2] ? 32'd0 : {17'd0, spacing};

  scr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  scr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .spacing   (spacing),
    .touch_x   (touch_x),
    .touch_y   (touch_y),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .point_x   (point_x),
    .point_y   (point_y),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .last      (last),
    .stat      (stat)
  );

endmodule
`default_nettype wire
